// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker in rhc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rhc check failed");

// next-cycle implication, ignored while reset is asserted
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rhc check failed");

`endif

// ===== sv/rhc_pkg.sv =====
package rhc_pkg;

    localparam int PIX_W  = 8;
    localparam int HUE_W  = 9;
    localparam int SAT_W  = 7;
    localparam int QUO_W  = 7;   // quotient bits, both quotients stay below 128
    localparam int NUM_W  = 15;  // dividend width, delta*100 and 60*|diff|
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = QPTR_W + 1;
    localparam int HSUM_W = 11;  // signed hue sum before wrap

    typedef logic [1:0] t_sector;
    localparam t_sector SECT_RED   = 2'd0;
    localparam t_sector SECT_GREEN = 2'd1;
    localparam t_sector SECT_BLUE  = 2'd2;

    // classified pixel, front to back
    typedef struct packed {
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] delta;
        logic [NUM_W-1:0] sat_n;
        logic [NUM_W-1:0] hue_n;
        logic             neg;
        t_sector          sector;
    } t_task;

    // one divider pipeline stage
    typedef struct packed {
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] delta;
        logic             neg;
        t_sector          sector;
        logic [NUM_W-1:0] sat_n;
        logic [PIX_W-1:0] sat_rem;
        logic [QUO_W-1:0] sat_q;
        logic [NUM_W-1:0] hue_n;
        logic [PIX_W-1:0] hue_rem;
        logic [QUO_W-1:0] hue_q;
    } t_stage;

    // one restoring division step: {new remainder, quotient bit}
    function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
                                                input logic             nbit,
                                                input logic [PIX_W-1:0] d);
        logic [PIX_W:0] t;
        logic [PIX_W:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {diff[PIX_W-1:0], 1'b1};
        end
        return {t[PIX_W-1:0], 1'b0};
    endfunction

endpackage

// ===== sv/pixel_if.sv =====
interface pixel_if;
    import rhc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/hsv_if.sv =====
interface hsv_if;
    import rhc_pkg::*;
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// ===== sv/rgb_to_hsv_converter.sv =====
// channel   modport  fields                               request taken when
// i_pix     sink     red 8, green 8, blue 8               valid && ready
// o_hsv     source   hue 9, saturation 7, brightness 8    valid && ready
//
// one pixel per cycle sustained while o_hsv is not stalled; a result passes the queue,
// the 7-step restoring divider pipeline in the back end and the output register
// i_rst_n is synchronous, active low, and empties queue and pipeline
// i_pix.ready drops only when the 4-entry queue is full
// an output stall freezes the back end while the queue keeps taking requests
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    pixel_if.sink i_pix,
    hsv_if.source o_hsv
);

    // front to queue
    logic  push, full;
    t_task push_task;

    // queue to back
    logic  head_valid, pop;
    t_task head_task;

    // front end: max/min pick, sector, dividends
    rhc_front u_front (
        .i_pix  (i_pix),
        .i_full (full),
        .o_push (push),
        .o_task (push_task)
    );

    // decoupling queue between classification and division
    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_task)
    );

    // back end: saturation and hue quotients side by side, then hue wrap
    rhc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (head_valid),
        .i_task       (head_task),
        .o_pop        (pop),
        .o_hsv        (o_hsv)
    );

endmodule

// ===== sv/rhc_front.sv =====
module rhc_front
    import rhc_pkg::*;
(
    pixel_if.sink   i_pix,
    input  logic    i_full,
    output logic    o_push,
    output t_task   o_task
);

    logic [PIX_W-1:0] r, g, b, lo;
    logic signed [PIX_W+1:0] diff;
    logic [PIX_W-1:0] mag;

    assign r = i_pix.red;
    assign g = i_pix.green;
    assign b = i_pix.blue;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    always_comb begin
        // ties go to red, then green
        if (r >= g && r >= b) begin
            o_task.sector = SECT_RED;
            o_task.hi     = r;
            diff          = $signed({2'b00, g}) - $signed({2'b00, b});
        end else if (g >= b) begin
            o_task.sector = SECT_GREEN;
            o_task.hi     = g;
            diff          = $signed({2'b00, b}) - $signed({2'b00, r});
        end else begin
            o_task.sector = SECT_BLUE;
            o_task.hi     = b;
            diff          = $signed({2'b00, r}) - $signed({2'b00, g});
        end
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        o_task.delta = o_task.hi - lo;
        o_task.neg   = diff[PIX_W+1];
        mag          = diff[PIX_W+1] ? PIX_W'(-diff) : diff[PIX_W-1:0];
        // delta*100 and 60*|diff| as shift-add
        o_task.sat_n = (NUM_W'(o_task.delta) << 6) + (NUM_W'(o_task.delta) << 5)
                     + (NUM_W'(o_task.delta) << 2);
        o_task.hue_n = (NUM_W'(mag) << 6) - (NUM_W'(mag) << 2);
    end

endmodule

// ===== sv/rhc_queue.sv =====
module rhc_queue
    import rhc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_task o_data
);

    t_task             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/rhc_back.sv =====
module rhc_back
    import rhc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_task_valid,
    input  t_task  i_task,
    output logic   o_pop,
    hsv_if.source  o_hsv
);

    t_stage           r_stg [QUO_W];
    t_stage           n_stg [QUO_W];
    logic [QUO_W-1:0] r_vld;
    logic             r_out_valid;
    logic [HUE_W-1:0] r_hue;
    logic [SAT_W-1:0] r_sat;
    logic [PIX_W-1:0] r_bri;
    logic             adv;
    logic [PIX_W:0]   s0, h0, sk, hk;
    logic [SAT_W-1:0] fin_sat;
    logic [HUE_W-1:0] fin_hue;
    logic signed [HSUM_W-1:0] hsum, hoff, hq;

    assign adv   = !r_out_valid || o_hsv.ready;
    assign o_pop = adv && i_task_valid;

    always_comb begin
        // first step straight from the queue head
        s0 = div_step(i_task.sat_n[NUM_W-1:QUO_W], i_task.sat_n[QUO_W-1], i_task.hi);
        h0 = div_step(i_task.hue_n[NUM_W-1:QUO_W], i_task.hue_n[QUO_W-1], i_task.delta);
        n_stg[0].hi      = i_task.hi;
        n_stg[0].delta   = i_task.delta;
        n_stg[0].neg     = i_task.neg;
        n_stg[0].sector  = i_task.sector;
        n_stg[0].sat_n   = i_task.sat_n;
        n_stg[0].hue_n   = i_task.hue_n;
        n_stg[0].sat_rem = s0[PIX_W:1];
        n_stg[0].hue_rem = h0[PIX_W:1];
        n_stg[0].sat_q   = {{(QUO_W-1){1'b0}}, s0[0]};
        n_stg[0].hue_q   = {{(QUO_W-1){1'b0}}, h0[0]};
        for (int s = 1; s < QUO_W; s++) begin
            sk = div_step(r_stg[s-1].sat_rem, r_stg[s-1].sat_n[QUO_W-1-s], r_stg[s-1].hi);
            hk = div_step(r_stg[s-1].hue_rem, r_stg[s-1].hue_n[QUO_W-1-s],
                          r_stg[s-1].delta);
            n_stg[s]         = r_stg[s-1];
            n_stg[s].sat_rem = sk[PIX_W:1];
            n_stg[s].hue_rem = hk[PIX_W:1];
            n_stg[s].sat_q   = {r_stg[s-1].sat_q[QUO_W-2:0], sk[0]};
            n_stg[s].hue_q   = {r_stg[s-1].hue_q[QUO_W-2:0], hk[0]};
        end
    end

    // black pixel and zero saturation force hue to zero
    always_comb begin
        fin_sat = (r_stg[QUO_W-1].hi == '0) ? '0 : r_stg[QUO_W-1].sat_q;
        unique case (r_stg[QUO_W-1].sector)
            SECT_RED:   hoff = HSUM_W'(0);
            SECT_GREEN: hoff = HSUM_W'(120);
            SECT_BLUE:  hoff = HSUM_W'(240);
            default:    hoff = HSUM_W'(0);
        endcase
        hq   = $signed({{(HSUM_W-QUO_W){1'b0}}, r_stg[QUO_W-1].hue_q});
        hsum = r_stg[QUO_W-1].neg ? hoff - hq : hoff + hq;
        if (hsum < 0) hsum = hsum + HSUM_W'(360);
        fin_hue = (fin_sat == '0) ? '0 : hsum[HUE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < QUO_W; s++) r_stg[s] <= n_stg[s];
            if (r_vld[QUO_W-1]) begin
                r_hue <= fin_hue;
                r_sat <= fin_sat;
                r_bri <= r_stg[QUO_W-1].hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[QUO_W-2:0], i_task_valid};
            r_out_valid <= r_vld[QUO_W-1];
        end
    end

    assign o_hsv.valid      = r_out_valid;
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_bri;

endmodule

// ===== sv/rhc_checker.sv =====
`include "assert_macros.svh"

module rhc_checker
    import rhc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [HUE_W-1:0] i_hue,
    input logic [SAT_W-1:0] i_sat,
    input logic [PIX_W-1:0] i_bri
);

    logic                         out_stall;
    logic [HUE_W+SAT_W+PIX_W-1:0] out_bits;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_bits  = {i_hue, i_sat, i_bri};

    // a stalled result holds
    `RHC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_bits))
    // percent and angle stay in range
    `RHC_ASSERT_IMP(a_ranges, i_clk, i_rst_n, i_out_valid, i_sat <= SAT_W'(100) && i_hue <= HUE_W'(359))
    // black pixel has no hue and no saturation
    `RHC_ASSERT_IMP(a_black, i_clk, i_rst_n, i_out_valid && i_bri == '0, i_sat == '0 && i_hue == '0)
    // no saturation means no hue
    `RHC_ASSERT_IMP(a_grey, i_clk, i_rst_n, i_out_valid && i_sat == '0, i_hue == '0)

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_hsv.valid),
    .i_out_ready (o_hsv.ready),
    .i_hue       (o_hsv.hue),
    .i_sat       (o_hsv.saturation),
    .i_bri       (o_hsv.brightness)
);

// ===== tb/hsv_checker.sv =====
`timescale 1ns / 1ps

module hsv_checker
    import rhc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pixel_if     i_pix,
    hsv_if       i_hsv,
    input  logic i_done,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [PIX_W-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        t_hsv             hsv;
    } t_hsv_due;

    t_hsv_due hsv_due[$];
    logic     done_seen = 1'b0;

    // integer hsv of one pixel, three-sector hue, truncating division
    function automatic t_hsv convert_pixel(input logic [PIX_W-1:0] r,
                                           input logic [PIX_W-1:0] g,
                                           input logic [PIX_W-1:0] b);
        t_hsv res;
        int   hi;
        int   lo;
        int   delta;
        int   sat;
        int   hue;
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        sat   = 0;
        hue   = 0;
        if (hi != 0) sat = (delta * 100) / hi;
        // hue only where saturation survives truncation, so delta is never zero here
        if (sat != 0) begin
            if (hi == r) begin
                hue = (60 * (int'(g) - int'(b))) / delta;
            end else if (hi == g) begin
                hue = (60 * (int'(b) - int'(r))) / delta + 120;
            end else begin
                hue = (60 * (int'(r) - int'(g))) / delta + 240;
            end
            if (hue < 0) hue += 360;
        end
        res.hue        = HUE_W'(hue);
        res.saturation = SAT_W'(sat);
        res.brightness = PIX_W'(hi);
        return res;
    endfunction

    task automatic report(input string what);
        $display("[%0t] hsv check: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_hsv_due want;
        if (!i_rst_n) begin
            hsv_due.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                want.red   = i_pix.red;
                want.green = i_pix.green;
                want.blue  = i_pix.blue;
                want.hsv   = convert_pixel(i_pix.red, i_pix.green, i_pix.blue);
                hsv_due.push_back(want);
            end
            if (i_hsv.valid && i_hsv.ready) begin
                if (hsv_due.size() == 0) begin
                    report($sformatf("result h%0d s%0d v%0d with no pixel pending",
                                     i_hsv.hue, i_hsv.saturation, i_hsv.brightness));
                end else begin
                    want = hsv_due.pop_front();
                    o_checked++;
                    if (i_hsv.hue !== want.hsv.hue)
                        report($sformatf("rgb %0d,%0d,%0d hue %0d want %0d",
                                         want.red, want.green, want.blue,
                                         i_hsv.hue, want.hsv.hue));
                    if (i_hsv.saturation !== want.hsv.saturation)
                        report($sformatf("rgb %0d,%0d,%0d saturation %0d want %0d",
                                         want.red, want.green, want.blue,
                                         i_hsv.saturation, want.hsv.saturation));
                    if (i_hsv.brightness !== want.hsv.brightness)
                        report($sformatf("rgb %0d,%0d,%0d brightness %0d want %0d",
                                         want.red, want.green, want.blue,
                                         i_hsv.brightness, want.hsv.brightness));
                end
            end
            if (i_done && !done_seen) begin
                done_seen <= 1'b1;
                if (hsv_due.size() != 0)
                    report($sformatf("%0d results never arrived", hsv_due.size()));
            end
        end
        o_pending <= hsv_due.size();
    end

endmodule

// ===== tb/tb_rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;
    import rhc_pkg::*;

    // cycles with no request moving on either channel before the run is called hung
    localparam int IDLE_LIMIT = 4000;
    // extra wait once nothing is pending, so any straggler can still show
    localparam int SETTLE_CYCLES = 16;

    // hand-picked pixels: rails, greys, each sector, ties, truncation corners
    localparam logic [23:0] CORNER_PX [22] = '{
        24'h000000,  // black, max is zero
        24'hFFFFFF,  // white, grey at full scale
        24'h808080,  // mid grey
        24'h010101,  // darkest non-black grey
        24'hFF0000,  // pure red
        24'h00FF00,  // pure green
        24'h0000FF,  // pure blue
        24'hFFFF00,  // red ties green, red wins
        24'h00FFFF,  // green ties blue, green wins
        24'hFF00FF,  // red ties blue, red wins
        24'hFFFEFE,  // saturation truncates to zero, hue forced to zero
        24'h646363,  // smallest nonzero saturation
        24'hFF0001,  // negative hue quotient truncates to zero
        24'hFF00C8,  // negative hue wraps by 360
        24'hFF00FE,  // negative hue wraps by 360, quotient 59 in the red sector
        24'h010000,  // tiny red, full saturation
        24'h000100,  // tiny green
        24'h000001,  // tiny blue
        24'hFF8000,  // orange
        24'h0080FF,  // azure
        24'hC86496,  // red sector, mixed channels
        24'h3C1E5A   // blue sector, dark
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic stim_done = 1'b0;

    int   gap_odds   = 0;   // sender idles about one request in gap_odds, 0 never
    int   stall_odds = 0;   // receiver starts a stall about one cycle in stall_odds, 0 never
    int   sink_hold  = 0;
    int   idle_cycles = 0;
    int   pixels_sent = 0;
    int   drains      = 0;

    int   fail_count;
    int   pending;
    int   checked;

    pixel_if pix_ch ();
    hsv_if   hsv_ch ();

    rgb_to_hsv_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_ch),
        .o_hsv   (hsv_ch)
    );

    hsv_checker hsv_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_ch),
        .i_hsv        (hsv_ch),
        .i_done       (stim_done),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #4 clk = ~clk;

    // idle stretch length: mostly short, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // channel value pinned to a rail or left random
    function automatic logic [PIX_W-1:0] rail_val();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // random pixel, biased toward greys, ties, rails and dark colors
    task automatic pick_pixel(output logic [PIX_W-1:0] r,
                              output logic [PIX_W-1:0] g,
                              output logic [PIX_W-1:0] b);
        int base;
        int lo;
        base = $urandom_range(3, 255);
        lo   = $urandom_range(0, base);
        r = PIX_W'($urandom);
        g = PIX_W'($urandom);
        b = PIX_W'($urandom);
        case ($urandom_range(0, 9))
            4: begin
                // near grey, saturation often truncates to zero
                r = PIX_W'(base - $urandom_range(0, 3));
                g = PIX_W'(base - $urandom_range(0, 3));
                b = PIX_W'(base - $urandom_range(0, 3));
            end
            5: begin
                // two channels tied for largest
                case ($urandom_range(0, 2))
                    0:       begin r = PIX_W'(base); g = PIX_W'(base); b = PIX_W'(lo); end
                    1:       begin g = PIX_W'(base); b = PIX_W'(base); r = PIX_W'(lo); end
                    default: begin r = PIX_W'(base); b = PIX_W'(base); g = PIX_W'(lo); end
                endcase
            end
            6: begin
                r = rail_val();
                g = rail_val();
                b = rail_val();
            end
            7: begin
                // dark, small max and small deltas
                r = PIX_W'($urandom_range(0, 7));
                g = PIX_W'($urandom_range(0, 7));
                b = PIX_W'($urandom_range(0, 7));
            end
            default: ;
        endcase
    endtask

    // offer one pixel request and hold it until taken; called and left at a falling edge
    task automatic push_pixel(input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = idle_len();
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        @(negedge clk);
        pixels_sent++;
    endtask

    // stop sending until every pending result has come back
    task automatic wait_drain();
        pix_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        drains++;
    endtask

    task automatic push_random(input int count);
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        for (int n = 0; n < count; n++) begin
            pick_pixel(r, g, b);
            push_pixel(r, g, b);
        end
    endtask

    // result side backpressure, changed on the falling edge
    always @(negedge clk) begin
        if (sink_hold != 0) begin
            sink_hold      <= sink_hold - 1;
            hsv_ch.ready   <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            sink_hold      <= idle_len() - 1;
            hsv_ch.ready   <= 1'b0;
        end else begin
            hsv_ch.ready   <= 1'b1;
        end
    end

    // watchdog: any request moving on either side clears the count
    always @(posedge clk) begin
        if (rst_n) begin
            if ((pix_ch.valid && pix_ch.ready) || (hsv_ch.valid && hsv_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
                $display("rgb_to_hsv_converter verification failed");
                $finish;
            end
        end
    end

    initial begin
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;

        // synchronous reset, held low and then released at a falling edge
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners back to back with the receiver always ready
        foreach (CORNER_PX[k])
            push_pixel(CORNER_PX[k][23:16], CORNER_PX[k][15:8], CORNER_PX[k][7:0]);
        wait_drain();

        // random traffic with idling on both sides, draining now and then
        gap_odds   = 4;
        stall_odds = 5;
        for (int blk = 0; blk < 4; blk++) begin
            push_random(125);
            wait_drain();
        end

        // full rate, no idling on either side
        gap_odds   = 0;
        stall_odds = 0;
        push_random(300);

        // heavy receiver stalls against a sender that never pauses, queue runs full
        stall_odds = 2;
        push_random(300);

        // mixed idling to finish
        gap_odds   = 3;
        stall_odds = 4;
        push_random(200);

        // let the pipeline empty, then give stragglers time to show
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        stim_done <= 1'b1;
        repeat (2) @(negedge clk);

        $display("covered %0d pixels: %0d corner cases, random greys, ties, rails, dark tones",
                 pixels_sent, $size(CORNER_PX));
        $display("compared %0d results under idle, full rate and stalled traffic, %0d drains",
                 checked, drains);
        if (fail_count == 0) begin
            $display("rgb_to_hsv_converter verification clean");
        end else begin
            $display("rgb_to_hsv_converter verification failed");
        end
        $finish;
    end

endmodule

// ===== rgb_to_hsv_converter.f =====
+incdir+sv
sv/rhc_pkg.sv
sv/pixel_if.sv
sv/hsv_if.sv
sv/rhc_front.sv
sv/rhc_queue.sv
sv/rhc_back.sv
sv/rgb_to_hsv_converter.sv
sv/rhc_checker.sv
tb/hsv_checker.sv
tb/tb_rgb_to_hsv_converter.sv
